@@ design/pcmfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM sample format packer package
// Shared format codes, register indexes and pipeline payload types.
// ----------------------------------------------------------------------------
package pcmfp_pkg;

   localparam logic [2:0] KIND_S16 = 3'd0;
   localparam logic [2:0] KIND_S24 = 3'd1;
   localparam logic [2:0] KIND_S32 = 3'd2;
   localparam logic [2:0] KIND_U16 = 3'd3;
   localparam logic [2:0] KIND_U24 = 3'd4;
   localparam logic [2:0] KIND_U32 = 3'd5;
   localparam logic [2:0] KIND_F32 = 3'd6;
   localparam logic [2:0] KIND_F64 = 3'd7;

   localparam logic [1:0] ORDER_NATIVE = 2'd0;
   localparam logic [1:0] ORDER_LE     = 2'd1;
   localparam logic [1:0] ORDER_BE     = 2'd2;

   localparam int NUM_KINDS  = 8;
   localparam int NUM_ORDERS = 3;

   localparam logic [1:0] REG_FORMAT        = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_NATIVE_LE     = 2'd2;

   localparam logic [3:0] BYTES_2 = 4'd2;
   localparam logic [3:0] BYTES_4 = 4'd4;
   localparam logic [3:0] BYTES_8 = 4'd8;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [1:0] order;
   } fmt_decode_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        little;
      logic        eob;
      logic        neg;
      logic [31:0] offset;
      logic [15:0] mag;
   } front_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        little;
      logic        eob;
      logic        neg;
      logic [15:0] level;
      logic [15:0] mag;
      logic [3:0]  lead;
      logic        zero;
   } quant_type;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        eob;
   } word_type;

   function automatic fmt_decode_type decode_format(input logic [4:0] code);
      fmt_decode_type d;
      d = '0;
      for (int k = 0; k < NUM_KINDS; k++) begin
         for (int o = 0; o < NUM_ORDERS; o++) begin
            if (code == 5'(NUM_ORDERS * k + o)) begin
               d.valid = 1'b1;
               d.kind  = 3'(k);
               d.order = 2'(o);
            end
         end
      end
      return d;
   endfunction

endpackage

@@ design/pcmfp_quant.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM sample quantizer
// Two pipeline stages: saturation and format decode, then the integer scale
// multiply and the leading-one search for the float path.
// ----------------------------------------------------------------------------
module pcmfp_quant (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [31:0]  sample_value,
   input  logic                end_of_buffer,
   input  logic [4:0]          format,
   input  logic                native_little_endian,
   input  logic                count_nonzero,
   output logic                out_valid,
   input  logic                out_ready,
   output pcmfp_pkg::quant_type out_data
);
   import pcmfp_pkg::*;

   localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
   localparam logic signed [31:0] M_ONE_Q30 = -32'sh4000_0000;
   localparam logic [15:0]        LEVEL_SCALE = 16'hFFFF;

   fmt_decode_type   fmt;
   logic signed [31:0] sat;
   logic [31:0]      abs_val;
   front_type        s1_in;
   front_type        s1_ff;
   logic             s1_valid_ff;
   logic             s2_ready;
   logic [47:0]      product;
   quant_type        s2_in;
   quant_type        s2_ff;
   logic             s2_valid_ff;

   always_comb begin
      fmt = decode_format(format);
      if (sample_value > ONE_Q30) begin
         sat = ONE_Q30;
      end else if (sample_value < M_ONE_Q30) begin
         sat = M_ONE_Q30;
      end else begin
         sat = sample_value;
      end
      abs_val      = sat[31] ? (~sat + 32'd1) : sat;
      s1_in.kind   = fmt.kind;
      s1_in.little = (fmt.order == ORDER_LE) ||
                     ((fmt.order == ORDER_NATIVE) && native_little_endian);
      s1_in.eob    = end_of_buffer;
      s1_in.neg    = sat[31];
      s1_in.offset = sat + ONE_Q30;
      s1_in.mag    = abs_val[30:15];
   end

   assign in_ready = !s1_valid_ff || s2_ready;
   assign s2_ready = !s2_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid && fmt.valid && count_nonzero;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_ff <= s1_in;
      end
   end

   always_comb begin
      product      = 48'(s1_ff.offset) * 48'(LEVEL_SCALE);
      s2_in.kind   = s1_ff.kind;
      s2_in.little = s1_ff.little;
      s2_in.eob    = s1_ff.eob;
      s2_in.neg    = s1_ff.neg;
      s2_in.level  = product[46:31];
      s2_in.mag    = s1_ff.mag;
      s2_in.zero   = (s1_ff.mag == 16'd0);
      s2_in.lead   = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (s1_ff.mag[i]) begin
            s2_in.lead = 4'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

@@ design/pcmfp_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM word packer
// Builds the integer or IEEE word for the format and applies the byte order.
// ----------------------------------------------------------------------------
module pcmfp_pack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pcmfp_pkg::quant_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pcmfp_pkg::word_type  out_data
);
   import pcmfp_pkg::*;

   localparam logic [15:0] SIGN_FLIP = 16'h8000;
   localparam logic [7:0]  EXP_BIAS_F32 = 8'd112;
   localparam logic [10:0] EXP_BIAS_F64 = 11'd1008;

   logic        signed_kind;
   logic [15:0] w16;
   logic [7:0]  ext;
   logic [15:0] norm;
   logic [63:0] raw_word;
   logic [3:0]  nbytes;
   logic [63:0] swapped;
   word_type    s3_in;
   word_type    s3_ff;
   logic        s3_valid_ff;

   always_comb begin
      signed_kind = (in_data.kind == KIND_S16) || (in_data.kind == KIND_S24) ||
                    (in_data.kind == KIND_S32);
      w16  = signed_kind ? (in_data.level ^ SIGN_FLIP) : in_data.level;
      ext  = signed_kind ? {8{w16[15]}} : 8'h00;
      norm = in_data.mag << (4'd15 - in_data.lead);
      unique case (in_data.kind)
         KIND_S16, KIND_U16: begin
            raw_word = {48'h0, w16};
            nbytes   = BYTES_2;
         end
         KIND_S24, KIND_U24: begin
            raw_word = {32'h0, ext, w16, 8'h00};
            nbytes   = BYTES_4;
         end
         KIND_S32, KIND_U32: begin
            raw_word = {32'h0, w16, 16'h0000};
            nbytes   = BYTES_4;
         end
         KIND_F32: begin
            raw_word = in_data.zero ? 64'h0 :
                       {32'h0, in_data.neg, EXP_BIAS_F32 + 8'(in_data.lead),
                        norm[14:0], 8'h00};
            nbytes   = BYTES_4;
         end
         default: begin
            raw_word = in_data.zero ? 64'h0 :
                       {in_data.neg, EXP_BIAS_F64 + 11'(in_data.lead),
                        norm[14:0], 37'h0};
            nbytes   = BYTES_8;
         end
      endcase
      unique case (nbytes)
         BYTES_2: swapped = {48'h0, raw_word[7:0], raw_word[15:8]};
         BYTES_4: swapped = {32'h0, raw_word[7:0], raw_word[15:8],
                             raw_word[23:16], raw_word[31:24]};
         default: swapped = {raw_word[7:0], raw_word[15:8], raw_word[23:16],
                             raw_word[31:24], raw_word[39:32], raw_word[47:40],
                             raw_word[55:48], raw_word[63:56]};
      endcase
      s3_in.word   = in_data.little ? raw_word : swapped;
      s3_in.nbytes = nbytes;
      s3_in.eob    = in_data.eob;
   end

   assign in_ready = !s3_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

@@ design/pcmfp_repeat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM channel repeater
// Holds one packed word in the output register and emits one copy per channel.
// ----------------------------------------------------------------------------
module pcmfp_repeat #(
   parameter int MAX_CHANNELS = 32,
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pcmfp_pkg::word_type in_data,
   input  logic [CNT_W-1:0]    channel_count,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,
   output logic [4:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import pcmfp_pkg::*;

   word_type         hold_ff;
   logic             valid_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic             last;

   assign idx_in   = idx_ff + CNT_W'(1);
   assign last     = (idx_in == channel_count);
   assign in_ready = !valid_ff || (rsp_tready && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
         idx_ff   <= '0;
      end else if (rsp_tready) begin
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         hold_ff <= in_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = hold_ff.word;
   assign rsp_tuser  = {last & hold_ff.eob, hold_ff.nbytes};
   assign rsp_tlast  = last;

endmodule

@@ design/pcm_sample_format_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM sample format packer
// Converts a Q30 mono sample to a packed PCM word and emits it per channel.
// ----------------------------------------------------------------------------
// A sample passes the quantizer stage registers, the packer register and the
// repeater hold register before its first copy is presented.
// The repeater emits one copy per cycle while the result side is ready, and
// loads the next packed word in the cycle that its last copy is taken.
// Reset is synchronous and active high; it empties the pipeline and restores
// format 0, one channel and native little-endian order.
// ----------------------------------------------------------------------------
module pcm_sample_format_packer #(
   parameter int MAX_CHANNELS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] sample_value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [63:0] sample_word
   output logic [4:0]  rsp_tuser,  // [3:0] word_bytes, [4] buffer_done
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);
   import pcmfp_pkg::*;

   localparam int         CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam logic [6:0] MAX_C7 = 7'(MAX_CHANNELS);

   logic [4:0]       format_ff;
   logic [5:0]       channel_count_ff;
   logic             native_le_ff;
   logic [6:0]       count_ext;
   logic [6:0]       count_sat;
   logic [CNT_W-1:0] count_eff;
   logic             q_valid;
   logic             q_ready;
   quant_type        q_data;
   logic             p_valid;
   logic             p_ready;
   word_type         p_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff        <= 5'd0;
         channel_count_ff <= 6'd1;
         native_le_ff     <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_FORMAT:        format_ff        <= csr_wdata[4:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata;
            REG_NATIVE_LE:     native_le_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign count_ext = {1'b0, channel_count_ff};
   assign count_sat = (count_ext > MAX_C7) ? MAX_C7 : count_ext;
   assign count_eff = count_sat[CNT_W-1:0];

   pcmfp_quant u_quant (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (req_tvalid),
      .in_ready             (req_tready),
      .sample_value         (req_tdata),
      .end_of_buffer        (req_tlast),
      .format               (format_ff),
      .native_little_endian (native_le_ff),
      .count_nonzero        (count_sat != 7'd0),
      .out_valid            (q_valid),
      .out_ready            (q_ready),
      .out_data             (q_data)
   );

   pcmfp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_data  (p_data)
   );

   pcmfp_repeat #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_repeat (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (p_valid),
      .in_ready      (p_ready),
      .in_data       (p_data),
      .channel_count (count_eff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

@@ test/pcm_sample_format_packer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM sample format packer testbench
// Streams Q30 samples into the packer under every format and byte order and random
// channel count settings, predicts each packed channel copy, and compares the copies
// that come out field by field while both stream sides stall at random.
// ----------------------------------------------------------------------------
module pcm_sample_format_packer_tb;
   import pcmfp_pkg::*;

   localparam int          MAX_CHANNELS  = 32;
   localparam longint      UNITY         = 64'sd1073741824;
   localparam int          RANDOM_ITEMS  = 450;
   localparam int          SETTLE_CYCLES = 10;
   localparam int          DRAIN_LIMIT   = 50000;
   localparam int unsigned CYCLE_LIMIT   = 2000000;

   localparam logic [1:0] REG_SPARE            = 2'd3;
   localparam logic [5:0] FORMAT_UNKNOWN       = 6'd24;
   localparam logic [5:0] FORMAT_WRAPS_UNKNOWN = 6'd63;

   class pcm_word_ledger;
      typedef struct {
         logic [63:0] word;
         logic [3:0]  nbytes;
         logic        last;
         logic        done;
      } pcm_copy_type;

      pcm_copy_type pending_copies[$];
      logic [4:0]   format_code;
      logic [5:0]   channel_count;
      logic         native_le;
      int           errors;

      function new();
         format_code   = '0;
         channel_count = 6'd1;
         native_le     = 1'b1;
         errors        = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [5:0] value);
         case (index)
            REG_FORMAT: begin
               format_code = value[4:0];
            end
            REG_CHANNEL_COUNT: begin
               channel_count = value;
            end
            REG_NATIVE_LE: begin
               native_le = value[0];
            end
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return pending_copies.size();
      endfunction

      // Returns the number of channel copies that the sample produces.
      function int note_sample(logic [31:0] value, logic eob);
         pcm_copy_type copy;
         logic [2:0]   kind;
         logic [1:0]   order;
         longint       level;
         longint       trunc;
         logic [63:0]  mag;
         logic [63:0]  frac;
         logic [63:0]  word;
         logic [63:0]  flipped;
         logic [3:0]   nbytes;
         logic         sign;
         logic         little;
         int           p;
         int           copies;
         if (format_code >= 5'd24) return 0;
         kind  = 3'(format_code / 3);
         order = 2'(format_code % 3);
         level = longint'($signed(value));
         if (level > UNITY) level = UNITY;
         if (level < -UNITY) level = -UNITY;
         if (kind >= KIND_F32) begin
            trunc = (level >= 0) ? (level >>> 15) : -((-level) >>> 15);
            sign  = (trunc < 0);
            mag   = sign ? 64'(-trunc) : 64'(trunc);
            p     = 0;
            while ((mag >> (p + 1)) != 0) p++;
            frac = mag - (64'd1 << p);
            if (kind == KIND_F64) begin
               nbytes = BYTES_8;
               word   = {sign, 11'(1008 + p), 52'(frac << (52 - p))};
            end else begin
               nbytes = BYTES_4;
               word   = {32'd0, sign, 8'(112 + p), 23'(frac << (23 - p))};
            end
            if (mag == 0) word = '0;
         end else begin
            level = longint'((64'(level + UNITY) * 64'd65535) >> 31);
            if (kind < KIND_U16) level = level - 32768;
            case (int'(kind) % 3)
               0: begin
                  word   = {48'd0, level[15:0]};
                  nbytes = BYTES_2;
               end
               1: begin
                  word   = {32'd0, level[23:0], 8'd0};
                  nbytes = BYTES_4;
               end
               default: begin
                  word   = {32'd0, level[15:0], 16'd0};
                  nbytes = BYTES_4;
               end
            endcase
         end
         little = (order == ORDER_LE) || (order == ORDER_NATIVE && native_le);
         if (!little) begin
            flipped = '0;
            for (int i = 0; i < nbytes; i++)
               flipped = (flipped << 8) | ((word >> (8 * i)) & 64'hFF);
            word = flipped;
         end
         copies = (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_count);
         for (int c = 0; c < copies; c++) begin
            copy.word   = word;
            copy.nbytes = nbytes;
            copy.last   = (c + 1 == copies);
            copy.done   = (c + 1 == copies) && eob;
            pending_copies.push_back(copy);
         end
         return copies;
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
      endtask

      task check_copy(logic [63:0] word, logic [3:0] nbytes, logic last, logic done);
         pcm_copy_type want;
         if (pending_copies.size() == 0) begin
            report_mismatch("transaction with nothing pending", word, '0);
            return;
         end
         want = pending_copies.pop_front();
         if (word !== want.word) report_mismatch("sample_word", word, want.word);
         if (nbytes !== want.nbytes)
            report_mismatch("word_bytes", 64'(nbytes), 64'(want.nbytes));
         if (last !== want.last)
            report_mismatch("last_channel", 64'(last), 64'(want.last));
         if (done !== want.done)
            report_mismatch("buffer_done", 64'(done), 64'(want.done));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;  // [31:0] sample_value
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;  // [63:0] sample_word
   logic [4:0]  rsp_tuser;  // [3:0] word_bytes, [4] buffer_done
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [5:0]  csr_wdata;

   pcm_word_ledger ledger = new();
   bit             steady = 1'b0;
   int             productive = 0;
   int unsigned    cycle_count = 0;

   pcm_sample_format_packer #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_copy(rsp_tdata, rsp_tuser[3:0], rsp_tlast, rsp_tuser[4]);
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic logic [5:0] format_of(logic [2:0] kind, logic [1:0] order);
      return 6'(NUM_ORDERS * kind + order);
   endfunction

   function automatic logic [31:0] random_sample();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 32'($urandom_range(32'h8000_0000, 0)) - 32'h4000_0000;
      if (r < 80) begin
         case ($urandom_range(4))
            0: return 32'h4000_0000;
            1: return 32'hC000_0000;
            2: return 32'($urandom_range(80000)) - 32'd40000;
            3: return 32'h4000_0000 - 32'($urandom_range(70000));
            default: return 32'hC000_0000 + 32'($urandom_range(70000));
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [5:0] pick_channels();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 6'($urandom_range(4, 1));
      if (r < 88) return 6'($urandom_range(32, 5));
      if (r < 94) return 6'd32;
      if (r < 97) return 6'd0;
      return 6'($urandom_range(63, 33));
   endfunction

   initial begin : result_sink
      int gap;
      int burst;
      rsp_tready = 1'b0;
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         burst = $urandom_range(12, 1);
         repeat (burst - 1) @(negedge clock);
      end
   end

   task automatic send_sample(input logic [31:0] value, input logic eob);
      int gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= eob;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (ledger.note_sample(value, eob) > 0) productive++;
   endtask

   // Stops the sender and waits until every predicted copy has come out.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [5:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ledger.set_register(index, value);
   endtask

   initial begin : stimulus
      int phase;
      int count;
      int r;
      int waited;
      logic [5:0] fmt;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: signed 16-bit, one channel, little-endian.
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h4000_0000, 1'b0);
      send_sample(32'hC000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h3FFF_FFFF, 1'b0);
      send_sample(32'hC000_0001, 1'b1);

      // Oversized channel count and tiny negative floats, then unity, in big-endian order.
      write_reg(REG_CHANNEL_COUNT, 6'd63);
      write_reg(REG_FORMAT, format_of(KIND_F32, ORDER_NATIVE));
      write_reg(REG_NATIVE_LE, 6'd0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_8001, 1'b0);
      send_sample(32'hFFFF_8000, 1'b0);
      send_sample(32'h4000_0000, 1'b1);

      write_reg(REG_FORMAT, format_of(KIND_F64, ORDER_BE));
      write_reg(REG_CHANNEL_COUNT, 6'd2);
      send_sample(32'h4000_0000, 1'b0);
      send_sample(32'hC000_0000, 1'b0);
      send_sample(32'd12345678, 1'b1);

      // Unknown format codes and a zero channel count emit nothing.
      write_reg(REG_FORMAT, FORMAT_WRAPS_UNKNOWN);
      send_sample(32'h1234_5678, 1'b0);
      send_sample(32'hC000_0000, 1'b1);
      write_reg(REG_FORMAT, FORMAT_UNKNOWN);
      send_sample(32'h0000_0000, 1'b1);
      write_reg(REG_SPARE, 6'h3F);
      write_reg(REG_FORMAT, format_of(KIND_S32, ORDER_LE));
      write_reg(REG_CHANNEL_COUNT, 6'd0);
      send_sample(32'h0000_0001, 1'b0);
      write_reg(REG_CHANNEL_COUNT, 6'd1);
      send_sample(32'hC000_0000, 1'b1);

      productive = 0;
      phase = 0;
      while (productive < RANDOM_ITEMS) begin
         steady = ($urandom_range(5) == 0);
         r = $urandom_range(99);
         if (phase < NUM_KINDS * NUM_ORDERS) fmt = 6'(phase);
         else if (r < 90) fmt = 6'($urandom_range(23));
         else fmt = 6'($urandom_range(63, 24));
         write_reg(REG_FORMAT, fmt);
         write_reg(REG_CHANNEL_COUNT, pick_channels());
         write_reg(REG_NATIVE_LE, 6'($urandom));
         if ($urandom_range(7) == 0) write_reg(REG_SPARE, 6'($urandom));
         count = $urandom_range(24, 8);
         for (int i = 0; i < count; i++) begin
            if (phase == 6 && i == count / 2) settle();
            send_sample(random_sample(), $urandom_range(7) == 0);
         end
         phase++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (ledger.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.pending() != 0)
         ledger.report_mismatch("copies never delivered", 64'(ledger.pending()), '0);
      if (ledger.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ pcm_sample_format_packer.f @@
design/pcmfp_pkg.sv
design/pcmfp_quant.sv
design/pcmfp_pack.sv
design/pcmfp_repeat.sv
design/pcm_sample_format_packer.sv
test/pcm_sample_format_packer_tb.sv
